// ----- hw/rtl/conservative_to_primitive_2d_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the conservative-to-primitive converter
// Shared concurrent check forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONSERVATIVE_TO_PRIMITIVE_2D_MACROS_SVH
`define CONSERVATIVE_TO_PRIMITIVE_2D_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CTP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition holds at every edge out of reset
`define CTP_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("invariant check failed");

`endif

// ----- hw/rtl/ctp_pkg.sv -----
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared data type and saturation limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctp_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // magnitude limits for positive and negative results
    localparam logic [DATA_W-1:0] POS_LIM = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_LIM = 32'h8000_0000;

    // configuration register indexes
    localparam logic CFG_GAMMA_M1 = 1'b0;
    localparam logic CFG_INV_R    = 1'b1;

endpackage

// ----- hw/rtl/conservative_to_primitive_2d.sv -----
// Throughput: one item per cycle while m_ready takes the result; the two bit-per-stage
//   divider chains (64 stages for kinetic energy, 32 + FRAC_BITS for the quotients)
//   set the pipeline depth. The default FRAC_BITS of 16 gives Q16.16.
// One shared advance enable stalls every stage while the result waits.
// Reset (aresetn low, synchronous) empties the pipeline and restores
//   gamma - 1 to 0.4 and 1/R to 1.0.
// ----------------------------------------------------------------------------
// conservative_to_primitive_2d
// Ideal-gas 2D cell: conserved (rho, rho*u, rho*v, E) to primitive
// (rho, u, v, p, T) in signed fixed point with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "conservative_to_primitive_2d_macros.svh"

module conservative_to_primitive_2d import ctp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [30:0] cfg_data,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  data_t       s_density,
    input  data_t       s_momentum_x,
    input  data_t       s_momentum_y,
    input  data_t       s_total_energy,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output data_t       m_density_out,
    output data_t       m_velocity_x,
    output data_t       m_velocity_y,
    output data_t       m_pressure,
    output data_t       m_temperature,
    output logic        m_bad_density,
    output logic        m_saturated
);

    localparam int QW = DATA_W + FRAC_BITS;   // shifted dividend / quotient width
    localparam logic [16:0] GM1_RESET  = 17'((2 << FRAC_BITS) / 5);
    localparam logic [30:0] INVR_RESET = 31'(1 << FRAC_BITS);

    // sideband carried through the kinetic-energy divider
    typedef struct packed {
        data_t rho;
        data_t mx;
        data_t my;
        data_t en;
        logic  bad;
    } ke_pay_t;

    // sideband through the pressure multiplier
    typedef struct packed {
        data_t rho;
        data_t mx;
        data_t my;
        logic  bad;
    } p_pay_t;

    // sideband through the temperature quotient divider
    typedef struct packed {
        logic  negp;
        data_t rho;
        data_t p;
        logic  bad;
        logic  satp;
    } t_pay_t;

    // sideband through the temperature multiplier
    typedef struct packed {
        data_t u;
        data_t v;
        logic  satuv;
        data_t rho;
        data_t p;
        logic  bad;
        logic  satp;
    } o_pay_t;

    // ---------------------------------------------------------------- config
    logic [16:0] gm1_reg;
    logic [30:0] inv_r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gm1_reg   <= GM1_RESET;
            inv_r_reg <= INVR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GAMMA_M1: gm1_reg   <= cfg_data[16:0];
                CFG_INV_R:    inv_r_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Whole pipeline moves together; the output register frees up when taken.
    logic adv;
    logic m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ------------------------------------------------ stage 0: input capture
    logic  v0_reg;
    data_t rho0_reg, mx0_reg, my0_reg, en0_reg;

    // ------------------------------------------- stage 1: squared momentum
    logic  v1_reg, bad1_reg;
    data_t rho1_reg, mx1_reg, my1_reg, en1_reg;
    logic signed [63:0] sqx1_next, sqy1_next;
    logic [63:0] sqx1_reg, sqy1_reg;

    assign sqx1_next = mx0_reg * mx0_reg;
    assign sqy1_next = my0_reg * my0_reg;

    // ------------------------------------------- stage 2: sum and 2*rho
    logic        v2_reg;
    logic [63:0] sq2_reg;
    logic [31:0] den2_reg;
    ke_pay_t     pay2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rho0_reg <= s_density;
            mx0_reg  <= s_momentum_x;
            my0_reg  <= s_momentum_y;
            en0_reg  <= s_total_energy;

            rho1_reg <= rho0_reg;
            mx1_reg  <= mx0_reg;
            my1_reg  <= my0_reg;
            en1_reg  <= en0_reg;
            bad1_reg <= rho0_reg <= 0;
            sqx1_reg <= sqx1_next;
            sqy1_reg <= sqy1_next;

            sq2_reg      <= sqx1_reg + sqy1_reg;
            den2_reg     <= {rho1_reg[30:0], 1'b0};
            pay2_reg.rho <= rho1_reg;
            pay2_reg.mx  <= mx1_reg;
            pay2_reg.my  <= my1_reg;
            pay2_reg.en  <= en1_reg;
            pay2_reg.bad <= bad1_reg;
        end
    end

    // ----------------------------------- kinetic energy: sq / (2 * rho)
    logic        vk;
    logic [63:0] ke;
    ke_pay_t     payk;

    ctp_div #(
        .NUM_W (64),
        .DEN_W (32),
        .PAY_W ($bits(ke_pay_t))
    ) u_div_ke (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v2_reg),
        .in_num    (sq2_reg),
        .in_den    (den2_reg),
        .in_pay    (pay2_reg),
        .out_valid (vk),
        .out_quo   (ke),
        .out_pay   (payk)
    );

    // ----------------------------- stage 3: internal energy, stage 4: abs
    logic               v3_reg, v4_reg;
    logic signed [63:0] eint3_reg;
    p_pay_t             pay3_reg, pay4_reg;
    logic [63:0]        emag4_reg;
    logic               eneg4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= vk;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            eint3_reg    <= 64'(payk.en) - $signed(ke);
            pay3_reg.rho <= payk.rho;
            pay3_reg.mx  <= payk.mx;
            pay3_reg.my  <= payk.my;
            pay3_reg.bad <= payk.bad;

            eneg4_reg <= eint3_reg[63];
            emag4_reg <= eint3_reg[63] ? 64'(-eint3_reg) : 64'(eint3_reg);
            pay4_reg  <= pay3_reg;
        end
    end

    // ------------------------------------ pressure: eint * (gamma - 1)
    logic   vp;
    data_t  p_val;
    logic   p_sat;
    p_pay_t payp;

    ctp_mulsat #(
        .FRAC_BITS (FRAC_BITS),
        .MAG_W     (64),
        .G_W       (17),
        .PAY_W     ($bits(p_pay_t))
    ) u_mul_p (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v4_reg),
        .in_mag    (emag4_reg),
        .in_neg    (eneg4_reg),
        .in_g      (gm1_reg),
        .in_pay    (pay4_reg),
        .out_valid (vp),
        .out_val   (p_val),
        .out_sat   (p_sat),
        .out_pay   (payp)
    );

    // ----------------------------- stage 5: shifted dividend magnitudes
    logic [DATA_W-1:0] amx, amy, ap;
    logic              v5_reg, negx5_reg, negy5_reg;
    logic [QW-1:0]     nx5_reg, ny5_reg, np5_reg;
    logic [30:0]       den5_reg;
    t_pay_t            pay5_reg;

    assign amx = payp.mx[31] ? DATA_W'(-payp.mx) : DATA_W'(payp.mx);
    assign amy = payp.my[31] ? DATA_W'(-payp.my) : DATA_W'(payp.my);
    assign ap  = p_val[31]   ? DATA_W'(-p_val)   : DATA_W'(p_val);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= vp;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nx5_reg       <= {amx, FRAC_BITS'(0)};
            ny5_reg       <= {amy, FRAC_BITS'(0)};
            np5_reg       <= {ap, FRAC_BITS'(0)};
            negx5_reg     <= payp.mx[31];
            negy5_reg     <= payp.my[31];
            den5_reg      <= payp.rho[30:0];
            pay5_reg.negp <= p_val[31];
            pay5_reg.rho  <= payp.rho;
            pay5_reg.p    <= p_val;
            pay5_reg.bad  <= payp.bad;
            pay5_reg.satp <= p_sat;
        end
    end

    // ------------------------------ quotients: u, v and p / rho in parallel
    logic          vu, vv, vt;
    logic [QW-1:0] qu, qv, qt;
    logic          negu, negv;
    t_pay_t        payt;

    ctp_div #(
        .NUM_W (QW),
        .DEN_W (31),
        .PAY_W (1)
    ) u_div_u (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v5_reg),
        .in_num    (nx5_reg),
        .in_den    (den5_reg),
        .in_pay    (negx5_reg),
        .out_valid (vu),
        .out_quo   (qu),
        .out_pay   (negu)
    );

    ctp_div #(
        .NUM_W (QW),
        .DEN_W (31),
        .PAY_W (1)
    ) u_div_v (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v5_reg),
        .in_num    (ny5_reg),
        .in_den    (den5_reg),
        .in_pay    (negy5_reg),
        .out_valid (vv),
        .out_quo   (qv),
        .out_pay   (negv)
    );

    ctp_div #(
        .NUM_W (QW),
        .DEN_W (31),
        .PAY_W ($bits(t_pay_t))
    ) u_div_t (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v5_reg),
        .in_num    (np5_reg),
        .in_den    (den5_reg),
        .in_pay    (pay5_reg),
        .out_valid (vt),
        .out_quo   (qt),
        .out_pay   (payt)
    );

    // saturate a quotient magnitude to 32 bits signed: {sat, value}
    function automatic logic [DATA_W:0] quo_sat(input logic [QW-1:0] q, input logic neg);
        logic [QW-1:0]     lim;
        logic              over;
        logic [DATA_W-1:0] mag;
        lim  = neg ? QW'(NEG_LIM) : QW'(POS_LIM);
        over = q > lim;
        mag  = over ? lim[DATA_W-1:0] : q[DATA_W-1:0];
        return {over, neg ? DATA_W'(-mag) : mag};
    endfunction

    logic [DATA_W:0] us, vs;
    o_pay_t          payo_in;

    assign us = quo_sat(qu, negu);
    assign vs = quo_sat(qv, negv);

    always_comb begin
        payo_in.u     = data_t'(us[DATA_W-1:0]);
        payo_in.v     = data_t'(vs[DATA_W-1:0]);
        payo_in.satuv = us[DATA_W] | vs[DATA_W];
        payo_in.rho   = payt.rho;
        payo_in.p     = payt.p;
        payo_in.bad   = payt.bad;
        payo_in.satp  = payt.satp;
    end

    // ----------------------------------- temperature: t1 * (1 / R)
    logic   vo;
    data_t  t_val;
    logic   t_sat;
    o_pay_t payo;

    ctp_mulsat #(
        .FRAC_BITS (FRAC_BITS),
        .MAG_W     (QW),
        .G_W       (31),
        .PAY_W     ($bits(o_pay_t))
    ) u_mul_t (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (vu & vv & vt),
        .in_mag    (qt),
        .in_neg    (payt.negp),
        .in_g      (inv_r_reg),
        .in_pay    (payo_in),
        .out_valid (vo),
        .out_val   (t_val),
        .out_sat   (t_sat),
        .out_pay   (payo)
    );

    // ------------------------------------------------------ result register
    data_t rho_o_reg, u_o_reg, v_o_reg, p_o_reg, t_o_reg;
    logic  bad_o_reg, sat_o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vo;
        end
    end

    // non-positive density forces every field but the flag to zero
    always_ff @(posedge aclk) begin
        if (adv) begin
            rho_o_reg <= payo.bad ? '0 : payo.rho;
            u_o_reg   <= payo.bad ? '0 : payo.u;
            v_o_reg   <= payo.bad ? '0 : payo.v;
            p_o_reg   <= payo.bad ? '0 : payo.p;
            t_o_reg   <= payo.bad ? '0 : t_val;
            bad_o_reg <= payo.bad;
            sat_o_reg <= !payo.bad && (payo.satuv || payo.satp || t_sat);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_density_out = rho_o_reg;
    assign m_velocity_x  = u_o_reg;
    assign m_velocity_y  = v_o_reg;
    assign m_pressure    = p_o_reg;
    assign m_temperature = t_o_reg;
    assign m_bad_density = bad_o_reg;
    assign m_saturated   = sat_o_reg;

    // ------------------------------------------------------------ checks
    `CTP_ASSERT_IMPLIES(a_bad_zero, aclk, aresetn, m_valid && m_bad_density, m_density_out == 0 && m_velocity_x == 0 && m_velocity_y == 0 && m_pressure == 0 && m_temperature == 0)
    `CTP_ASSERT_IMPLIES(a_good_rho, aclk, aresetn, m_valid && !m_bad_density, m_density_out > 0)
    `CTP_ASSERT_ALWAYS(a_bad_nosat, aclk, aresetn, !m_valid || !m_bad_density || !m_saturated)

endmodule

// ----- hw/rtl/ctp_div.sv -----
// ----------------------------------------------------------------------------
// ctp_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_div import ctp_pkg::*; #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32,
    parameter int PAY_W = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quo,
    output logic [PAY_W-1:0] out_pay
);

    // nq: remaining dividend bits on top, quotient bits shifted in below
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [PAY_W-1:0] pay_reg [NUM_W];
    logic             vld_reg [NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [PAY_W-1:0] pay_in;
        logic             vld_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] nq_next;

        if (i == 0) begin : g_first
            assign nq_in  = in_num;
            assign rem_in = '0;
            assign den_in = in_den;
            assign pay_in = in_pay;
            assign vld_in = in_valid;
        end else begin : g_rest
            assign nq_in  = nq_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign pay_in = pay_reg[i-1];
            assign vld_in = vld_reg[i-1];
        end

        assign trial    = {rem_in, nq_in[NUM_W-1]};
        assign ge       = trial >= {1'b0, den_in};
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        assign nq_next  = {nq_in[NUM_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (adv) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                nq_reg[i]  <= nq_next;
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_in;
                pay_reg[i] <= pay_in;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_quo   = nq_reg[NUM_W-1];
    assign out_pay   = pay_reg[NUM_W-1];

endmodule

// ----- hw/rtl/ctp_mulsat.sv -----
// ----------------------------------------------------------------------------
// ctp_mulsat
// Sign-magnitude times unsigned gain, shifted down, saturated to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_mulsat import ctp_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int MAG_W     = 64,
    parameter int G_W       = 17,
    parameter int PAY_W     = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [MAG_W-1:0] in_mag,
    input  logic             in_neg,
    input  logic [G_W-1:0]   in_g,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output data_t            out_val,
    output logic             out_sat,
    output logic [PAY_W-1:0] out_pay
);

    localparam int HI_W = MAG_W - DATA_W;
    localparam int AW   = HI_W + G_W;
    localparam int BW   = DATA_W + G_W;

    logic [AW-1:0]    a_reg, a_next;
    logic [BW-1:0]    b_reg, b_next;
    logic             neg_reg;
    logic [PAY_W-1:0] pay_a_reg;
    logic             vld_a_reg;

    data_t            val_reg, val_next;
    logic             sat_reg, sat_next;
    logic [PAY_W-1:0] pay_b_reg;
    logic             vld_b_reg;

    logic [63:0]       r;
    logic [63:0]       lim;
    logic              over;
    logic [DATA_W-1:0] mag;

    // split the magnitude into high and low words
    assign a_next = AW'(in_mag[MAG_W-1:DATA_W]) * AW'(in_g);
    assign b_next = BW'(in_mag[DATA_W-1:0]) * BW'(in_g);

    always_comb begin
        r        = (64'(a_reg) << (DATA_W - FRAC_BITS)) + (64'(b_reg) >> FRAC_BITS);
        lim      = neg_reg ? 64'(NEG_LIM) : 64'(POS_LIM);
        over     = (64'(a_reg) > 64'(POS_LIM)) || (r > lim);
        mag      = over ? lim[DATA_W-1:0] : r[DATA_W-1:0];
        val_next = neg_reg ? data_t'(-mag) : data_t'(mag);
        sat_next = over;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end else if (adv) begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            neg_reg   <= in_neg;
            pay_a_reg <= in_pay;
            val_reg   <= val_next;
            sat_reg   <= sat_next;
            pay_b_reg <= pay_a_reg;
        end
    end

    assign out_valid = vld_b_reg;
    assign out_val   = val_reg;
    assign out_sat   = sat_reg;
    assign out_pay   = pay_b_reg;

endmodule
